@@ design/assert_macros.svh @@
// Assertion macros for the design files; they sample on clk and are disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the cycle after.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/bft_pkg.sv @@
// Shared widths, codes and types of the triple-hash Bloom filter.
`timescale 1ns / 1ps

package bft_pkg;

	// Field widths of the request and response channels.
	localparam int KIND_W = 3;
	localparam int WORD_W = 32;
	localparam int IDX_W  = 9;
	localparam int BYTE_W = 8;

	// Configuration registers.
	localparam int FB_W       = 10;
	localparam int PC_W       = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_BYTES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROBE_COUNT  = 1'b1;

	localparam logic [FB_W-1:0] FB_RESET = 10'd512;
	localparam logic [PC_W-1:0] PC_RESET = 6'd7;

	// The modulus is eight times at most 1023 bytes, so it fits in 13 bits.
	localparam int M_W = 13;

	// The modulo unit retires two dividend bits per cycle.
	localparam int MOD_CYCLES = WORD_W / 2;
	localparam int STEP_W     = $clog2(MOD_CYCLES);

	// Request kinds.
	localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_LOAD   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_READ   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

	// Which hash word the modulo unit is reducing.
	typedef enum logic [1:0] {
		WSEL_A,
		WSEL_B,
		WSEL_C
	} wsel_t;

endpackage

@@ design/bft_if.sv @@
// Request and response channel interfaces of the triple-hash Bloom filter.
`timescale 1ns / 1ps

interface bft_req_if;
	import bft_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [WORD_W-1:0] hash_word_a;
	logic [WORD_W-1:0] hash_word_b;
	logic [WORD_W-1:0] hash_word_c;
	logic [IDX_W-1:0]  byte_index;
	logic [BYTE_W-1:0] byte_value;

	modport source (
		output valid, kind, hash_word_a, hash_word_b, hash_word_c, byte_index, byte_value,
		input  ready
	);
	modport sink (
		input  valid, kind, hash_word_a, hash_word_b, hash_word_c, byte_index, byte_value,
		output ready
	);
endinterface

interface bft_rsp_if;
	import bft_pkg::*;

	logic              valid;
	logic              ready;
	logic              present;
	logic [BYTE_W-1:0] byte_out;

	modport source (output valid, present, byte_out, input ready);
	modport sink (input valid, present, byte_out, output ready);
endinterface

@@ design/bft_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module bft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/bloom_filter_triple_hash.sv @@
// Top level of the triple-hash Bloom filter: sequencer, shared modulo unit and bit store.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage.
// Requests arrive on req (valid/ready); each request yields exactly one response on rsp.
// Kinds: insert, query, load byte, read byte, clear store; other kinds answer zeros.
// The block works on one request at a time and raises req.ready only when idle.
// Insert and query: the shared modulo unit reduces the three hash words, two bits a
// cycle; then each probe reads the store, then tests or sets its bit. A query that
// finds a clear bit stops early; with a zero modulus the modulo unit and probes are skipped.
// Load byte writes the byte into the store; read byte reads the store, waits for the
// data, then answers; clear store clears the whole store before it answers.
// After reset the store is cleared by a pass over all MAX_BYTES bytes, one byte a
// cycle, with req.ready low; configuration writes are taken meanwhile.
// The response sits in an output register. While the receiver stalls, one more request
// is accepted and worked off; its result then waits until the output register is free.
// Configuration is written through cfg_we, cfg_index and cfg_data while the block is idle;
// the user must keep to this, since the block itself does not enforce it.

module bloom_filter_triple_hash #(
	parameter int MAX_BYTES  = 512,
	parameter int MAX_PROBES = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bft_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bft_pkg::CFG_DATA_W-1:0] cfg_data,
	bft_req_if.sink                        req,
	bft_rsp_if.source                      rsp
);
	import bft_pkg::*;

	localparam int AW  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam int PCW = $clog2(MAX_PROBES + 1);

	typedef enum logic [8:0] {
		ST_CLEAR     = 9'b0_0000_0001,
		ST_IDLE      = 9'b0_0000_0010,
		ST_MOD       = 9'b0_0000_0100,
		ST_PROBE_RD  = 9'b0_0000_1000,
		ST_PROBE_CHK = 9'b0_0001_0000,
		ST_LOAD      = 9'b0_0010_0000,
		ST_READ      = 9'b0_0100_0000,
		ST_RD_WAIT   = 9'b0_1000_0000,
		ST_DONE      = 9'b1_0000_0000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [FB_W-1:0] filter_bytes_q;
	logic [PC_W-1:0] probe_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_bytes_q <= FB_RESET;
			probe_count_q  <= PC_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FILTER_BYTES: filter_bytes_q <= cfg_data;
				CFG_PROBE_COUNT:  probe_count_q  <= cfg_data[PC_W-1:0];
			endcase
		end
	end

	// Modulus and probe count that a new request will use.
	logic [31:0]    fb_ext;
	logic [31:0]    used_bytes;
	logic [M_W-1:0] m_w;
	logic [31:0]    pc_ext;
	logic [PCW-1:0] n_w;

	always_comb begin
		fb_ext     = 32'(filter_bytes_q);
		used_bytes = (fb_ext > 32'(MAX_BYTES)) ? 32'(MAX_BYTES) : fb_ext;
		m_w        = M_W'(used_bytes << 3);
		pc_ext     = 32'(probe_count_q);
		if (pc_ext == 32'd0) begin
			n_w = PCW'(1);
		end else if (pc_ext > 32'(MAX_PROBES)) begin
			n_w = PCW'(MAX_PROBES);
		end else begin
			n_w = PCW'(pc_ext);
		end
	end

	// Request and working registers.
	logic              clear_item_q;
	logic [AW-1:0]     clr_cnt_q;
	logic [KIND_W-1:0] kind_q;
	logic [WORD_W-1:0] wb_q;
	logic [WORD_W-1:0] wc_q;
	logic [IDX_W-1:0]  bidx_q;
	logic [BYTE_W-1:0] bval_q;
	logic [WORD_W-1:0] div_q;
	logic [M_W-1:0]    rem_q;
	logic [STEP_W-1:0] step_q;
	wsel_t             sel_q;
	logic [M_W-1:0]    m_q;
	logic [M_W-1:0]    x_q;
	logic [M_W-1:0]    y_q;
	logic [M_W-1:0]    z_q;
	logic [PCW-1:0]    n_q;
	logic [PCW-1:0]    pidx_q;
	logic              res_present_q;
	logic [BYTE_W-1:0] res_byte_q;
	logic              out_valid_q;
	logic              out_present_q;
	logic [BYTE_W-1:0] out_byte_q;

	// Shared modulo unit: two restoring compare-and-subtract steps per cycle.
	logic [M_W:0]   r1_full;
	logic [M_W-1:0] r1;
	logic [M_W:0]   r2_full;
	logic [M_W-1:0] r2;

	always_comb begin
		r1_full = {rem_q, div_q[WORD_W-1]};
		if (r1_full >= {1'b0, m_q}) begin
			r1_full = r1_full - {1'b0, m_q};
		end
		r1 = r1_full[M_W-1:0];
		r2_full = {r1, div_q[WORD_W-2]};
		if (r2_full >= {1'b0, m_q}) begin
			r2_full = r2_full - {1'b0, m_q};
		end
		r2 = r2_full[M_W-1:0];
	end

	// Probe advance: x and y step by y and z, each folded back below m.
	logic [M_W:0]   sx;
	logic [M_W:0]   sy;
	logic [M_W-1:0] x_next;
	logic [M_W-1:0] y_next;

	always_comb begin
		sx = {1'b0, x_q} + {1'b0, y_q};
		if (sx >= {1'b0, m_q}) begin
			sx = sx - {1'b0, m_q};
		end
		sy = {1'b0, y_q} + {1'b0, z_q};
		if (sy >= {1'b0, m_q}) begin
			sy = sy - {1'b0, m_q};
		end
		x_next = sx[M_W-1:0];
		y_next = sy[M_W-1:0];
	end

	// Store addressing and access.
	logic [31:0]       probe_ext;
	logic [AW-1:0]     probe_addr;
	logic [31:0]       bidx_ext;
	logic [AW-1:0]     byte_addr;
	logic              bidx_in_range;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [BYTE_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;
	logic [BYTE_W-1:0] probe_mask;
	logic              probe_hit;
	logic              probe_last;
	logic              is_query;

	always_comb begin
		probe_ext     = 32'(x_q[M_W-1:3]);
		probe_addr    = probe_ext[AW-1:0];
		bidx_ext      = 32'(bidx_q);
		byte_addr     = bidx_ext[AW-1:0];
		bidx_in_range = bidx_ext < 32'(MAX_BYTES);
		probe_mask    = BYTE_W'(1) << x_q[2:0];
		probe_hit     = ram_rdata[x_q[2:0]];
		probe_last    = pidx_q == (n_q - PCW'(1));
		is_query      = kind_q == KIND_QUERY;
	end

	// Write port: clearing pass, byte load or probe set, never two at once.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_cnt_q;
		ram_wdata = '0;
		priority case (1'b1)
			state_q == ST_CLEAR: begin
				ram_we = 1'b1;
			end
			state_q == ST_LOAD: begin
				ram_we    = bidx_in_range;
				ram_waddr = byte_addr;
				ram_wdata = bval_q;
			end
			state_q == ST_PROBE_CHK && kind_q == KIND_INSERT: begin
				ram_we    = 1'b1;
				ram_waddr = probe_addr;
				ram_wdata = ram_rdata | probe_mask;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Read port: probe reads and byte reads.
	assign ram_re    = (state_q == ST_PROBE_RD) || (state_q == ST_READ);
	assign ram_raddr = (state_q == ST_PROBE_RD) ? probe_addr : byte_addr;

	bft_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(MAX_BYTES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Handshake signals.
	logic req_fire;
	logic out_free;

	assign req.ready = state_q == ST_IDLE;
	assign req_fire  = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clear_item_q <= 1'b0;
			clr_cnt_q    <= '0;
			step_q       <= '0;
			sel_q        <= WSEL_A;
			pidx_q       <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(MAX_BYTES - 1)) begin
						clr_cnt_q    <= '0;
						clear_item_q <= 1'b0;
						state_q      <= clear_item_q ? ST_DONE : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						step_q <= '0;
						sel_q  <= WSEL_A;
						pidx_q <= '0;
						unique case (req.kind)
							KIND_INSERT, KIND_QUERY: begin
								state_q <= (m_w == '0) ? ST_DONE : ST_MOD;
							end
							KIND_LOAD: state_q <= ST_LOAD;
							KIND_READ: state_q <= ST_READ;
							KIND_CLEAR: begin
								clear_item_q <= 1'b1;
								clr_cnt_q    <= '0;
								state_q      <= ST_CLEAR;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_MOD: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(MOD_CYCLES - 1)) begin
						step_q <= '0;
						unique case (sel_q)
							WSEL_A:  sel_q <= WSEL_B;
							WSEL_B:  sel_q <= WSEL_C;
							default: state_q <= ST_PROBE_RD;
						endcase
					end
				end
				ST_PROBE_RD: begin
					state_q <= ST_PROBE_CHK;
				end
				ST_PROBE_CHK: begin
					if ((is_query && !probe_hit) || probe_last) begin
						state_q <= ST_DONE;
					end else begin
						pidx_q  <= pidx_q + PCW'(1);
						state_q <= ST_PROBE_RD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_DONE;
				end
				ST_READ: begin
					state_q <= ST_RD_WAIT;
				end
				ST_RD_WAIT: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request payload, modulo unit datapath and probe registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					kind_q        <= req.kind;
					wb_q          <= req.hash_word_b;
					wc_q          <= req.hash_word_c;
					bidx_q        <= req.byte_index;
					bval_q        <= req.byte_value;
					m_q           <= m_w;
					n_q           <= n_w;
					div_q         <= req.hash_word_a;
					rem_q         <= '0;
					res_present_q <= 1'b0;
					res_byte_q    <= '0;
				end
			end
			ST_MOD: begin
				div_q <= div_q << 2;
				rem_q <= r2;
				if (step_q == STEP_W'(MOD_CYCLES - 1)) begin
					rem_q <= '0;
					unique case (sel_q)
						WSEL_A: begin
							x_q   <= r2;
							div_q <= wb_q;
						end
						WSEL_B: begin
							y_q   <= r2;
							div_q <= wc_q;
						end
						default: begin
							z_q <= r2;
						end
					endcase
				end
			end
			ST_PROBE_CHK: begin
				if (is_query && !probe_hit) begin
					res_present_q <= 1'b0;
				end else if (probe_last) begin
					res_present_q <= is_query;
				end else begin
					x_q <= x_next;
					y_q <= y_next;
				end
			end
			ST_RD_WAIT: begin
				res_byte_q <= bidx_in_range ? ram_rdata : '0;
			end
			default: begin
				res_byte_q <= res_byte_q;
			end
		endcase
	end

	// Output register: loaded from the done state when free, emptied when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_present_q <= res_present_q;
			out_byte_q    <= res_byte_q;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.present  = out_present_q;
	assign rsp.byte_out = out_byte_q;

	// The probe walk is in progress.
	logic in_probe;

	assign in_probe = (state_q == ST_PROBE_RD) || (state_q == ST_PROBE_CHK);

	// The modulo unit only runs with a nonzero modulus.
	`ASSERT_IMPL(a_mod_nonzero, state_q == ST_MOD, m_q != '0, "modulo unit running with m zero")

	// Probe positions stay reduced below the modulus during the walk.
	`ASSERT_IMPL(a_probe_reduced, in_probe, x_q < m_q && y_q < m_q, "probe not below m")

	// The probe counter never runs past the latched probe count.
	`ASSERT_IMPL(a_probe_count, in_probe, pidx_q < n_q, "probe counter past probe count")

	// A response is only raised from the done state.
	`ASSERT_NEXT(a_rsp_source, !out_valid_q && state_q != ST_DONE, !rsp.valid, "stray response")

endmodule
